/* hw/rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, skipped during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hw/rtl/i2cled_pkg.sv */
// types, constants and register map of the led selector register file
package i2cled_pkg;

  localparam int LAST_REGISTER = 9;
  localparam int LED_COUNT     = 16;
  localparam int BANK_DEPTH    = 10;

  localparam logic [3:0] REG_INPUT0 = 4'd0;
  localparam logic [3:0] REG_INPUT1 = 4'd1;
  localparam logic [3:0] REG_PSC0   = 4'd2;
  localparam logic [3:0] REG_PWM0   = 4'd3;
  localparam logic [3:0] REG_PSC1   = 4'd4;
  localparam logic [3:0] REG_PWM1   = 4'd5;
  localparam logic [3:0] REG_LS0    = 4'd6;
  localparam logic [3:0] REG_LS1    = 4'd7;
  localparam logic [3:0] REG_LS2    = 4'd8;
  localparam logic [3:0] REG_LS3    = 4'd9;
  localparam logic [3:0] REG_LAST   = 4'(BANK_DEPTH - 1);

  localparam logic [7:0] NO_POINTER  = 8'hFF;
  localparam logic [7:0] AUTOINC_PTR = 8'h10;
  localparam logic [4:0] PTR_WRAP    = 5'(LAST_REGISTER + 1);

  localparam logic [7:0] PSC_RESET = 8'hFF;
  localparam logic [7:0] PWM_RESET = 8'h80;
  localparam logic [7:0] LS_RESET  = 8'h55;
  localparam logic [7:0] BAD_READ_DATA = 8'hFF;

  typedef enum logic [1:0] {
    CMD_EVENT = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_BAD_READ  = 2'd1,
    ERR_BAD_WRITE = 2'd2,
    ERR_AI_ZERO   = 2'd3
  } err_t;

  typedef struct packed {
    logic [7:0] data_byte;
    cmd_t       command;
  } item_t;

  typedef struct packed {
    err_t       error_code;
    logic [7:0] read_byte;
  } result_t;

  localparam int ITEM_W   = $bits(item_t);
  localparam int RESULT_W = $bits(result_t);

endpackage

/* hw/rtl/i2cled_pipe_reg.sv */
// one valid/ready register stage
module i2cled_pipe_reg #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         valid_in,
  input  logic [W-1:0] data_in,
  output logic         ready_in,
  output logic         valid,
  output logic [W-1:0] data,
  input  logic         ready_out
);

  assign ready_in = !valid || ready_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_in) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && valid_in) begin
      data <= data_in;
    end
  end

endmodule

/* hw/rtl/i2cled_regs.sv */
// register bank, pointer and address flag with the per-transaction update
module i2cled_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  i2cled_pkg::item_t   item,
  output i2cled_pkg::result_t result
);

  logic [7:0] bank [i2cled_pkg::BANK_DEPTH];
  logic [7:0] bank_next [i2cled_pkg::BANK_DEPTH];
  logic [7:0] pointer;
  logic [7:0] pointer_next;
  logic       addr_received;
  logic       addr_received_next;
  logic [3:0] idx;
  logic [7:0] ptr_adv;
  logic [4:0] ptr_sum;
  logic [15:0] inputs_new;

  // on: set, off: clear, pwm codes: unchanged
  function automatic logic [15:0] derive(input logic [15:0] cur, input logic [31:0] sels);
    logic [15:0] r;
    r = cur;
    for (int p = 0; p < 16; p++) begin
      if (p < i2cled_pkg::LED_COUNT) begin
        if (sels[2*p +: 2] == 2'd0) begin
          r[p] = 1'b1;
        end else if (sels[2*p +: 2] == 2'd1) begin
          r[p] = 1'b0;
        end
      end
    end
    return r;
  endfunction

  assign idx = pointer[3:0];

  always_comb begin
    ptr_sum = {1'b0, pointer[3:0]} + 5'd1;
    if (ptr_sum >= i2cled_pkg::PTR_WRAP) begin
      ptr_sum = ptr_sum - i2cled_pkg::PTR_WRAP;
    end
    if (pointer != i2cled_pkg::NO_POINTER && pointer[4]) begin
      ptr_adv = {4'b0001, ptr_sum[3:0]};
    end else begin
      ptr_adv = pointer;
    end
  end

  always_comb begin
    bank_next          = bank;
    pointer_next       = pointer;
    addr_received_next = addr_received;
    result.read_byte   = 8'h00;
    result.error_code  = i2cled_pkg::ERR_NONE;
    inputs_new         = 16'h0000;
    if (go) begin
      unique case (item.command)
        i2cled_pkg::CMD_EVENT: begin
          addr_received_next = 1'b0;
        end
        i2cled_pkg::CMD_WRITE: begin
          if (!addr_received) begin
            pointer_next       = item.data_byte;
            addr_received_next = 1'b1;
          end else begin
            if (idx >= i2cled_pkg::REG_PSC0 && idx <= i2cled_pkg::REG_LAST) begin
              bank_next[idx] = item.data_byte;
              if (idx >= i2cled_pkg::REG_LS0) begin
                inputs_new = derive({bank[i2cled_pkg::REG_INPUT1], bank[i2cled_pkg::REG_INPUT0]},
                                    {bank_next[i2cled_pkg::REG_LS3],
                                     bank_next[i2cled_pkg::REG_LS2],
                                     bank_next[i2cled_pkg::REG_LS1],
                                     bank_next[i2cled_pkg::REG_LS0]});
                bank_next[i2cled_pkg::REG_INPUT0] = inputs_new[7:0];
                bank_next[i2cled_pkg::REG_INPUT1] = inputs_new[15:8];
              end
            end else begin
              result.error_code = i2cled_pkg::ERR_BAD_WRITE;
            end
            pointer_next = ptr_adv;
          end
        end
        i2cled_pkg::CMD_READ: begin
          if (idx <= i2cled_pkg::REG_LAST) begin
            result.read_byte = bank[idx];
          end else begin
            result.read_byte  = i2cled_pkg::BAD_READ_DATA;
            result.error_code = i2cled_pkg::ERR_BAD_READ;
          end
          if (pointer == i2cled_pkg::AUTOINC_PTR) begin
            result.error_code = i2cled_pkg::ERR_AI_ZERO;
          end
          pointer_next = ptr_adv;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank[i2cled_pkg::REG_INPUT0] <= 8'h00;
      bank[i2cled_pkg::REG_INPUT1] <= 8'h00;
      bank[i2cled_pkg::REG_PSC0]   <= i2cled_pkg::PSC_RESET;
      bank[i2cled_pkg::REG_PWM0]   <= i2cled_pkg::PWM_RESET;
      bank[i2cled_pkg::REG_PSC1]   <= i2cled_pkg::PSC_RESET;
      bank[i2cled_pkg::REG_PWM1]   <= i2cled_pkg::PWM_RESET;
      for (int i = int'(i2cled_pkg::REG_LS0); i < i2cled_pkg::BANK_DEPTH; i++) begin
        bank[i] <= i2cled_pkg::LS_RESET;
      end
      pointer       <= i2cled_pkg::NO_POINTER;
      addr_received <= 1'b0;
    end else begin
      bank          <= bank_next;
      pointer       <= pointer_next;
      addr_received <= addr_received_next;
    end
  end

endmodule

/* hw/rtl/i2c_led_selector_register_file_top.sv */
// top level of the led selector register file
//
//  port group   dir  payload (tdata, low bit first)
//  s_t*         in   command[1:0], data_byte[9:2], zero pad [15:10]
//  m_t*         out  read_byte[7:0], error_code[9:8], zero pad [15:10]
//
// one result per input transaction, one transaction per cycle sustained while m_tready stays high
// the input register feeds the update logic, which loads the result register
// the bank update and result come from one pass through the register update logic
// synchronous reset loads the register defaults, no clearing pass
// a stalled result stops the input side only once the input register is also full
module i2c_led_selector_register_file_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // command[1:0], data_byte[9:2], pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // read_byte[7:0], error_code[9:8], pad
);

  i2cled_pkg::item_t   in_item;
  i2cled_pkg::item_t   cur_item;
  i2cled_pkg::result_t result;
  i2cled_pkg::result_t out_result;
  logic                cur_valid;
  logic                out_ready_in;

  assign in_item.command   = i2cled_pkg::cmd_t'(s_tdata[1:0]);
  assign in_item.data_byte = s_tdata[9:2];

  i2cled_pipe_reg #(.W(i2cled_pkg::ITEM_W)) u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (s_tvalid),
    .data_in   (in_item),
    .ready_in  (s_tready),
    .valid     (cur_valid),
    .data      (cur_item),
    .ready_out (out_ready_in)
  );

  i2cled_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .go     (cur_valid && out_ready_in),
    .item   (cur_item),
    .result (result)
  );

  i2cled_pipe_reg #(.W(i2cled_pkg::RESULT_W)) u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (cur_valid),
    .data_in   (result),
    .ready_in  (out_ready_in),
    .valid     (m_tvalid),
    .data      (out_result),
    .ready_out (m_tready)
  );

  assign m_tdata = {6'b000000, out_result.error_code, out_result.read_byte};

endmodule

/* hw/rtl/i2cled_checker.sv */
// port-level checks for the led selector register file
`include "assert_macros.svh"

module i2cled_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  logic [7:0] out_byte;
  logic       bad_read_out;
  logic       bad_write_out;

  assign out_byte      = m_tdata[7:0];
  assign bad_read_out  = m_tvalid && m_tdata[9:8] == i2cled_pkg::ERR_BAD_READ;
  assign bad_write_out = m_tvalid && m_tdata[9:8] == i2cled_pkg::ERR_BAD_WRITE;

  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `ASSERT_IMPLIES(a_pad_zero, clk, rst, m_tvalid, m_tdata[15:10] == 6'b000000)
  `ASSERT_IMPLIES(a_bad_read_ff, clk, rst, bad_read_out, out_byte == i2cled_pkg::BAD_READ_DATA)
  `ASSERT_IMPLIES(a_bad_write_zero, clk, rst, bad_write_out, out_byte == 8'h00)
  `ASSERT_IMPLIES(a_stall_full, clk, rst, s_tvalid && !s_tready, m_tvalid && !m_tready)

endmodule

bind i2c_led_selector_register_file_top i2cled_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* test/i2c_led_selector_register_file_top_test.sv */
// testbench for the led selector register file: bus transactions checked against a predictor
`timescale 1ns / 100ps

module i2c_led_selector_register_file_top_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MISMATCH_SHOWN = 10;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] LED_ON = 2'd0;
  localparam logic [1:0] LED_OFF = 2'd1;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [15:0] s_tdata;  // command[1:0], data_byte[9:2], pad
  logic m_tvalid;
  logic m_tready;
  logic [15:0] m_tdata;  // read_byte[7:0], error_code[9:8], pad

  logic [7:0] led_regs [i2cled_pkg::BANK_DEPTH];
  logic [7:0] reg_ptr;
  logic addr_seen;
  i2cled_pkg::result_t pending_replies[$];

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_left = 0;

  i2c_led_selector_register_file_top u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void refresh_input_regs();
    logic [1:0] sel;
    for (int pin = 0; pin < i2cled_pkg::LED_COUNT; pin++) begin
      sel = led_regs[i2cled_pkg::REG_LS0 + pin / 4][(pin % 4) * 2 +: 2];
      if (sel == LED_ON) begin
        led_regs[i2cled_pkg::REG_INPUT0 + pin / 8][pin % 8] = 1'b1;
      end else if (sel == LED_OFF) begin
        led_regs[i2cled_pkg::REG_INPUT0 + pin / 8][pin % 8] = 1'b0;
      end
    end
  endfunction

  function automatic void reset_led_regs();
    led_regs[i2cled_pkg::REG_INPUT0] = 8'h00;
    led_regs[i2cled_pkg::REG_INPUT1] = 8'h00;
    led_regs[i2cled_pkg::REG_PSC0] = i2cled_pkg::PSC_RESET;
    led_regs[i2cled_pkg::REG_PWM0] = i2cled_pkg::PWM_RESET;
    led_regs[i2cled_pkg::REG_PSC1] = i2cled_pkg::PSC_RESET;
    led_regs[i2cled_pkg::REG_PWM1] = i2cled_pkg::PWM_RESET;
    for (int i = int'(i2cled_pkg::REG_LS0); i < i2cled_pkg::BANK_DEPTH; i++) begin
      led_regs[i] = i2cled_pkg::LS_RESET;
    end
    refresh_input_regs();
    reg_ptr = i2cled_pkg::NO_POINTER;
    addr_seen = 1'b0;
  endfunction

  function automatic void step_pointer();
    if (reg_ptr != i2cled_pkg::NO_POINTER && (reg_ptr & i2cled_pkg::AUTOINC_PTR) != 8'h00) begin
      reg_ptr = i2cled_pkg::AUTOINC_PTR |
                8'((5'(reg_ptr[3:0]) + 5'd1) % i2cled_pkg::PTR_WRAP);
    end
  endfunction

  function automatic i2cled_pkg::result_t apply_bus_item(logic [1:0] cmd, logic [7:0] data);
    i2cled_pkg::result_t r;
    logic [3:0] idx;
    r.read_byte = 8'h00;
    r.error_code = i2cled_pkg::ERR_NONE;
    idx = reg_ptr[3:0];
    case (cmd)
      i2cled_pkg::CMD_EVENT: addr_seen = 1'b0;
      i2cled_pkg::CMD_WRITE: begin
        if (!addr_seen) begin
          reg_ptr = data;
          addr_seen = 1'b1;
        end else begin
          if (idx >= i2cled_pkg::REG_PSC0 && idx <= i2cled_pkg::REG_LAST) begin
            led_regs[idx] = data;
            if (idx >= i2cled_pkg::REG_LS0) refresh_input_regs();
          end else begin
            r.error_code = i2cled_pkg::ERR_BAD_WRITE;
          end
          step_pointer();
        end
      end
      i2cled_pkg::CMD_READ: begin
        if (idx <= i2cled_pkg::REG_LAST) begin
          r.read_byte = led_regs[idx];
        end else begin
          r.read_byte = i2cled_pkg::BAD_READ_DATA;
          r.error_code = i2cled_pkg::ERR_BAD_READ;
        end
        if (reg_ptr == i2cled_pkg::AUTOINC_PTR) r.error_code = i2cled_pkg::ERR_AI_ZERO;
        step_pointer();
      end
      default: ;
    endcase
    return r;
  endfunction

  // called just after a falling edge, returns just after a falling edge
  task automatic send_bus_item(input logic [1:0] cmd, input logic [7:0] data);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, data, cmd};
    do @(posedge clk); while (!s_tready);
    pending_replies.push_back(apply_bus_item(cmd, data));
    @(negedge clk);
  endtask

  task automatic wait_for_replies();
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_pointer();
    case ($urandom_range(3))
      0: return 8'($urandom_range(255));
      3: return 8'($urandom_range(15));
      default: return i2cled_pkg::AUTOINC_PTR | 8'($urandom_range(i2cled_pkg::LAST_REGISTER));
    endcase
  endfunction

  task automatic test_register_defaults();
    send_bus_item(i2cled_pkg::CMD_EVENT, 8'h00);
    send_bus_item(i2cled_pkg::CMD_WRITE, i2cled_pkg::AUTOINC_PTR);
    repeat (i2cled_pkg::BANK_DEPTH + 1) send_bus_item(i2cled_pkg::CMD_READ, 8'hFF);
    wait_for_replies();
  endtask

  task automatic test_special_cases();
    send_bus_item(i2cled_pkg::CMD_EVENT, 8'hFF);
    send_bus_item(i2cled_pkg::CMD_WRITE, i2cled_pkg::NO_POINTER);
    send_bus_item(i2cled_pkg::CMD_READ, 8'h00);
    send_bus_item(i2cled_pkg::CMD_WRITE, 8'h55);
    send_bus_item(CMD_UNUSED, 8'hFF);
    send_bus_item(i2cled_pkg::CMD_EVENT, 8'h00);
    send_bus_item(i2cled_pkg::CMD_WRITE, i2cled_pkg::AUTOINC_PTR | 8'(i2cled_pkg::REG_LS0));
    send_bus_item(i2cled_pkg::CMD_WRITE, 8'h00);
    send_bus_item(i2cled_pkg::CMD_WRITE, 8'hAA);
    send_bus_item(i2cled_pkg::CMD_WRITE, 8'hFF);
    send_bus_item(i2cled_pkg::CMD_WRITE, 8'h55);
    send_bus_item(i2cled_pkg::CMD_READ, 8'h00);
    send_bus_item(i2cled_pkg::CMD_READ, 8'h00);
    send_bus_item(i2cled_pkg::CMD_EVENT, 8'h00);
    send_bus_item(i2cled_pkg::CMD_WRITE, 8'h1F);
    send_bus_item(i2cled_pkg::CMD_WRITE, 8'h5A);
    send_bus_item(i2cled_pkg::CMD_READ, 8'h00);
    wait_for_replies();
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    @(posedge clk);
    hold_left = 60;
    @(negedge clk);
    send_bus_item(i2cled_pkg::CMD_EVENT, 8'h00);
    send_bus_item(i2cled_pkg::CMD_WRITE,
                  i2cled_pkg::AUTOINC_PTR | 8'($urandom_range(i2cled_pkg::LAST_REGISTER)));
    repeat (22) send_bus_item(2'($urandom_range(2, 1)), 8'($urandom_range(255)));
    wait_for_replies();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_items);
    int sent;
    int accesses;
    sent = 0;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    while (sent < n_items) begin
      if ($urandom_range(99) < 85) begin
        accesses = $urandom_range(8, 1);
        send_bus_item(i2cled_pkg::CMD_EVENT, 8'($urandom_range(255)));
        send_bus_item(i2cled_pkg::CMD_WRITE, pick_pointer());
        repeat (accesses) begin
          send_bus_item($urandom_range(1) ? i2cled_pkg::CMD_WRITE : i2cled_pkg::CMD_READ,
                        8'($urandom_range(255)));
        end
        sent += accesses + 2;
      end else begin
        send_bus_item(2'($urandom_range(3)), 8'($urandom_range(255)));
        sent++;
      end
    end
    wait_for_replies();
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    i2cled_pkg::result_t got;
    i2cled_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = i2cled_pkg::result_t'(m_tdata[i2cled_pkg::RESULT_W-1:0]);
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MISMATCH_SHOWN) begin
          $display("unexpected transaction: read_byte %02h error_code %0d",
                   got.read_byte, got.error_code);
        end
      end else begin
        want = pending_replies.pop_front();
        if (got.read_byte !== want.read_byte || got.error_code !== want.error_code) begin
          mismatches++;
          if (mismatches <= MISMATCH_SHOWN) begin
            $display("mismatch: expected %02h/%0d, got %02h/%0d (read_byte/error_code)",
                     want.read_byte, want.error_code, got.read_byte, got.error_code);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    reset_led_regs();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_register_defaults();
    test_special_cases();
    test_backpressure();
    test_random_traffic(0, 0, 300);
    test_random_traffic(78, 0, 300);
    test_random_traffic(0, 78, 300);
    test_random_traffic(26, 26, 300);

    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
